// File: rtl/waitable_counter_wait_slots_assert.svh
// ----------------------------------------------------------------------------
// waitable counter assertion macros
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// Users must have clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef WAITABLE_COUNTER_WAIT_SLOTS_ASSERT_SVH
`define WAITABLE_COUNTER_WAIT_SLOTS_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock outside reset
`define WCWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wcws assertion failed");
// condition must never be seen outside reset
`define WCWS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("wcws forbidden condition seen");
`else
`define WCWS_ASSERT(lbl, prop)
`define WCWS_NEVER(lbl, expr)
`endif
`endif

// File: rtl/wcws_pkg.sv
// ----------------------------------------------------------------------------
// wcws_pkg
// Shared types and constants of the waitable counter with wait slots.
// ----------------------------------------------------------------------------
package wcws_pkg;

  // field widths
  localparam int COUNT_W    = 32;
  localparam int FIBER_W    = 16;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // operation codes on the input tuser
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_REG = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // result kinds on the output tuser
  typedef enum logic [2:0] {
    KIND_ACK       = 3'd0,
    KIND_RELEASED  = 3'd1,
    KIND_STORED    = 3'd2,
    KIND_SATISFIED = 3'd3,
    KIND_FULL      = 3'd4
  } kind_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REL_PICK,
    ST_REL_EMIT,
    ST_EMIT_LAST
  } state_t;

  // classified command
  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] amount;
    logic [FIBER_W-1:0] fiber;
    logic [COUNT_W-1:0] target;
  } cmd_t;

  // one result beat
  typedef struct packed {
    kind_t              kind;
    logic [FIBER_W-1:0] fiber;
    logic [COUNT_W-1:0] prior;
    logic               last;
  } res_t;

endpackage

// File: rtl/wcws_ram.sv
// ----------------------------------------------------------------------------
// wcws_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wcws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/wcws_front.sv
// ----------------------------------------------------------------------------
// wcws_front
// Input stage: takes beats, drops unused operations, hands commands to the
// queue.
// ----------------------------------------------------------------------------
module wcws_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // amount, fiber_id, target_value
  input  logic [wcws_pkg::IN_DATA_W-1:0] s_tdata,
  // operation
  input  logic [wcws_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output wcws_pkg::cmd_t                 q_cmd
);
  import wcws_pkg::*;

  logic held;
  cmd_t held_cmd;
  cmd_t in_cmd;
  logic in_take;

  // unpack the beat
  always_comb begin
    in_cmd.op     = op_t'(s_tuser[1:0]);
    in_cmd.amount = s_tdata[31:0];
    in_cmd.fiber  = s_tdata[47:32];
    in_cmd.target = s_tdata[79:48];
  end

  assign s_tready = !held || !q_full;
  assign in_take  = s_tvalid && s_tready;
  assign q_push   = held && !q_full;
  assign q_cmd    = held_cmd;

  // holding register, unused operation codes never enter it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_take) begin
      held <= (in_cmd.op != OP_NOP);
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_cmd <= in_cmd;
    end
  end

endmodule

// File: rtl/wcws_queue.sv
// ----------------------------------------------------------------------------
// wcws_queue
// Short command queue that lets front and back stall on their own.
// ----------------------------------------------------------------------------
`include "waitable_counter_wait_slots_assert.svh"
module wcws_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wcws_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output wcws_pkg::cmd_t pop_cmd
);
  import wcws_pkg::*;

  cmd_t               entry [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign full    = (fill == Q_CNT_W'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign pop_cmd = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // checks
  `WCWS_NEVER(a_q_overfill, fill > Q_CNT_W'(QUEUE_DEPTH))
  `WCWS_NEVER(a_q_push_full, push && full)
  `WCWS_NEVER(a_q_pop_empty, pop && !valid)

endmodule

// File: rtl/wcws_back.sv
// ----------------------------------------------------------------------------
// wcws_back
// Execution stage: counter, wait slot lanes, release sequencer and output
// register.
// ----------------------------------------------------------------------------
`include "waitable_counter_wait_slots_assert.svh"
module wcws_back #(
  parameter int WAIT_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  wcws_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fiber_id_out, prior_count
  output logic [wcws_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind
  output logic [wcws_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                            m_tlast
);
  import wcws_pkg::*;

  localparam int IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  state_t               state;
  state_t               state_next;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_sum;
  logic [WAIT_SLOTS-1:0] slot_free;
  logic [COUNT_W-1:0]   slot_target [WAIT_SLOTS];
  logic [WAIT_SLOTS-1:0] pend;
  logic [WAIT_SLOTS-1:0] match_vec;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     pend_idx;
  logic                 any_free;
  logic                 any_pend;
  logic                 is_update;
  logic                 out_ok;
  kind_t                reg_kind;
  res_t                 last_res;
  res_t                 out_res;
  logic                 out_valid;
  logic [FIBER_W-1:0]   ram_rdata;
  logic                 slot_we;
  logic                 do_update;
  logic                 do_register;
  logic                 do_match;
  logic                 do_release;
  logic                 load_rel;
  logic                 load_last;

  // index of the lowest set bit
  function automatic logic [IDX_W-1:0] low_idx(input logic [WAIT_SLOTS-1:0] v);
    logic [WAIT_SLOTS-1:0] one_hot;
    logic [IDX_W-1:0]      idx;
    one_hot = v & (~v + 1'b1);
    idx     = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) begin
      if (one_hot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // per-lane target compare
  always_comb begin
    match_vec = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) begin
      match_vec[i] = !slot_free[i] && (slot_target[i] == count);
    end
  end

  assign free_idx  = low_idx(slot_free);
  assign pend_idx  = low_idx(pend);
  assign any_free  = |slot_free;
  assign any_pend  = |pend;
  assign out_ok    = !out_valid || m_tready;
  assign is_update = (q_cmd.op == OP_ADD) || (q_cmd.op == OP_SUB);
  assign count_sum = (q_cmd.op == OP_SUB) ? count - q_cmd.amount : count + q_cmd.amount;
  assign slot_we   = do_register && any_free;

  // register answer
  always_comb begin
    if (!any_free) begin
      reg_kind = KIND_FULL;
    end else if (q_cmd.target == count) begin
      reg_kind = KIND_SATISFIED;
    end else begin
      reg_kind = KIND_STORED;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = is_update ? ST_MATCH : ST_EMIT_LAST;
        end
      end
      ST_MATCH:    state_next = ST_REL_PICK;
      ST_REL_PICK: state_next = any_pend ? ST_REL_EMIT : ST_EMIT_LAST;
      ST_REL_EMIT: begin
        if (out_ok) begin
          state_next = ST_REL_PICK;
        end
      end
      ST_EMIT_LAST: begin
        if (out_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer controls
  always_comb begin
    q_pop       = 1'b0;
    do_update   = 1'b0;
    do_register = 1'b0;
    do_match    = 1'b0;
    do_release  = 1'b0;
    load_rel    = 1'b0;
    load_last   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop       = q_valid;
        do_update   = q_valid && is_update;
        do_register = q_valid && !is_update;
      end
      ST_MATCH:     do_match   = 1'b1;
      ST_REL_PICK:  do_release = any_pend;
      ST_REL_EMIT:  load_rel   = out_ok;
      ST_EMIT_LAST: load_last  = out_ok;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      slot_free <= '1;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_update) begin
        count <= count_sum;
      end
      if (slot_we && (reg_kind == KIND_STORED)) begin
        slot_free[free_idx] <= 1'b0;
      end
      if (do_release) begin
        slot_free[pend_idx] <= 1'b1;
      end
      if (do_match) begin
        pend <= match_vec;
      end else if (do_release) begin
        pend[pend_idx] <= 1'b0;
      end
      if (load_rel || load_last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // targets, final result and output beat
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_target[free_idx] <= q_cmd.target;
    end
    if (do_update) begin
      last_res <= '{kind: KIND_ACK, fiber: '0, prior: count, last: 1'b1};
    end else if (do_register) begin
      last_res <= '{kind: reg_kind, fiber: q_cmd.fiber, prior: '0, last: 1'b1};
    end
    if (load_rel) begin
      out_res <= '{kind: KIND_RELEASED, fiber: ram_rdata, prior: '0, last: 1'b0};
    end else if (load_last) begin
      out_res <= last_res;
    end
  end

  // fiber index store, read one released slot at a time
  wcws_ram #(
    .WIDTH(FIBER_W),
    .DEPTH(WAIT_SLOTS),
    .AW   (IDX_W)
  ) u_fiber_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(free_idx),
    .wdata(q_cmd.fiber),
    .re   (do_release),
    .raddr(pend_idx),
    .rdata(ram_rdata)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.prior, out_res.fiber};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

  // checks
  `WCWS_NEVER(a_pend_occupied, |(pend & slot_free))
  `WCWS_ASSERT(a_last_kind, out_valid |-> (out_res.last == (out_res.kind != KIND_RELEASED)))
  `WCWS_ASSERT(a_count_hold, (state != ST_IDLE) |=> $stable(count))

endmodule

// File: rtl/waitable_counter_wait_slots.sv
// ----------------------------------------------------------------------------
// waitable_counter_wait_slots
// Shared 32-bit counter with a table of wait slots that release fibers.
// ----------------------------------------------------------------------------
//  port group   dir   tdata                          tuser          tlast
//  s_*          in    amount, fiber_id, target_value operation      -
//  m_*          out   fiber_id_out, prior_count      kind           last
//
//  An add or subtract steps through match, then a release pick and emit per
//  released waiter, then the last emit; a register command goes straight to
//  the last emit. Emits wait out output stalls. The release sequencer reads
//  one slot at a time through the fiber RAM. Reset clears the counter and frees
//  every slot. Input and output stall independently through a 2-deep command queue.
// ----------------------------------------------------------------------------
module waitable_counter_wait_slots #(
  parameter int WAIT_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // amount [31:0], fiber_id [47:32], target_value [79:48]
  input  logic [wcws_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  logic [wcws_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fiber_id_out [15:0], prior_count [47:16]
  output logic [wcws_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind [2:0]
  output logic [wcws_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                            m_tlast
);
  import wcws_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // input classification
  wcws_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  // command queue
  wcws_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_cmd (pop_cmd)
  );

  // execution
  wcws_back #(
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// File: verif/waitable_counter_wait_slots_checker.sv
// ----------------------------------------------------------------------------
// waitable_counter_wait_slots checker
// Watches both stream ports of the wait-slot counter, keeps its own copy of
// the counter and the slot table, predicts the result beats of every accepted
// command and compares them field by field, in order, with the output beats.
// ----------------------------------------------------------------------------
module waitable_counter_wait_slots_checker #(
  parameter int WAIT_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // amount [31:0], fiber_id [47:32], target_value [79:48]
  input  logic [wcws_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  logic [wcws_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // fiber_id_out [15:0], prior_count [47:16]
  input  logic [wcws_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind [2:0]
  input  logic [wcws_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                            m_tlast,
  output int                              fail_count,
  output int                              outstanding,
  output int                              beats_checked,
  output int                              releases_seen,
  output int                              fulls_seen
);
  import wcws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 100;

  // shadow of the counter and the slot table
  logic [COUNT_W-1:0] count_now;
  logic               slot_held   [WAIT_SLOTS];
  logic [FIBER_W-1:0] slot_fiber  [WAIT_SLOTS];
  logic [COUNT_W-1:0] slot_target [WAIT_SLOTS];

  // result beats still owed by the block, oldest first
  res_t awaited_beats[$];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    beats_checked = 0;
    releases_seen = 0;
    fulls_seen    = 0;
  end

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] result beat %0d: %s got 0x%0h, wanted 0x%0h",
               $time, beats_checked, what, got, want);
    fail_count++;
  endtask

  function automatic res_t make_beat(input kind_t kind, input logic [FIBER_W-1:0] fiber,
                                     input logic [COUNT_W-1:0] prior, input logic last);
    res_t beat;
    beat.kind  = kind;
    beat.fiber = fiber;
    beat.prior = prior;
    beat.last  = last;
    return beat;
  endfunction

  // apply one command to the shadow state and queue the beats it owes
  task automatic predict_counter_command(input op_t op, input logic [COUNT_W-1:0] amount,
                                         input logic [FIBER_W-1:0] fiber,
                                         input logic [COUNT_W-1:0] target);
    logic [COUNT_W-1:0] prior;
    bit                 placed;
    prior  = count_now;
    placed = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        count_now = (op == OP_ADD) ? prior + amount : prior - amount;
        // release matching waiters from slot 0 upward
        for (int s = 0; s < WAIT_SLOTS; s++) begin
          if (slot_held[s] && slot_target[s] == count_now) begin
            slot_held[s] = 1'b0;
            awaited_beats.push_back(make_beat(KIND_RELEASED, slot_fiber[s], '0, 1'b0));
          end
        end
        awaited_beats.push_back(make_beat(KIND_ACK, '0, prior, 1'b1));
      end
      OP_REG: begin
        // lowest free slot takes the waiter unless it is already satisfied
        for (int s = 0; s < WAIT_SLOTS; s++) begin
          if (!placed && !slot_held[s]) begin
            placed = 1'b1;
            if (target == count_now) begin
              awaited_beats.push_back(make_beat(KIND_SATISFIED, fiber, '0, 1'b1));
            end else begin
              slot_held[s]   = 1'b1;
              slot_fiber[s]  = fiber;
              slot_target[s] = target;
              awaited_beats.push_back(make_beat(KIND_STORED, fiber, '0, 1'b1));
            end
          end
        end
        if (!placed)
          awaited_beats.push_back(make_beat(KIND_FULL, fiber, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // compare one output beat with the oldest owed beat
  task automatic check_result_beat();
    res_t want;
    if (awaited_beats.size() == 0) begin
      report_mismatch("beat with nothing owed, kind", COUNT_W'(m_tuser), '0);
      return;
    end
    want = awaited_beats.pop_front();
    if (m_tuser !== want.kind)
      report_mismatch("kind", COUNT_W'(m_tuser), COUNT_W'(want.kind));
    if (m_tdata[15:0] !== want.fiber)
      report_mismatch("fiber_id_out", COUNT_W'(m_tdata[15:0]), COUNT_W'(want.fiber));
    if (m_tdata[47:16] !== want.prior)
      report_mismatch("prior_count", m_tdata[47:16], want.prior);
    if (m_tlast !== want.last)
      report_mismatch("last", COUNT_W'(m_tlast), COUNT_W'(want.last));
    if (want.kind == KIND_RELEASED)
      releases_seen++;
    if (want.kind == KIND_FULL)
      fulls_seen++;
    beats_checked++;
  endtask

  // sample both ports at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      count_now = '0;
      for (int s = 0; s < WAIT_SLOTS; s++)
        slot_held[s] = 1'b0;
      awaited_beats.delete();
    end else begin
      if (m_tvalid === 1'b1 && m_tready === 1'b1)
        check_result_beat();
      if (s_tvalid === 1'b1 && s_tready === 1'b1)
        predict_counter_command(op_t'(s_tuser), s_tdata[31:0], s_tdata[47:32],
                                s_tdata[79:48]);
    end
    outstanding = awaited_beats.size();
  end

endmodule

// File: verif/waitable_counter_wait_slots_tb.sv
// ----------------------------------------------------------------------------
// waitable_counter_wait_slots testbench
// Drives directed corner commands and then random command streams into the
// wait-slot counter under four idle patterns, one long output hold and
// pauses until the block drains; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module waitable_counter_wait_slots_tb;
  import wcws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAIT_SLOTS   = 16;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE       = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  int fail_count;
  int outstanding;
  int beats_checked;
  int releases_seen;
  int fulls_seen;

  // stimulus knobs and bookkeeping
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  logic               hold_req = 1'b0;
  int                 hold_left = 0;
  bit                 hold_taken = 1'b0;
  int                 cycle_count = 0;
  int                 sent = 0;
  int                 n_add = 0;
  int                 n_sub = 0;
  int                 n_reg = 0;
  int                 n_nop = 0;
  logic [COUNT_W-1:0] aim_count = '0;

  always #5 clk = ~clk;

  waitable_counter_wait_slots #(
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  waitable_counter_wait_slots_checker #(
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .releases_seen (releases_seen),
    .fulls_seen    (fulls_seen)
  );

  // result side: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("waitable_counter_wait_slots verification failed");
    $finish;
  end

  // offer one command beat and wait until it is taken
  task automatic send_command(input op_t op, input logic [COUNT_W-1:0] amount,
                              input logic [FIBER_W-1:0] fiber,
                              input logic [COUNT_W-1:0] target);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {target, fiber, amount};
    do @(posedge clk); while (s_tready !== 1'b1);
    case (op)
      OP_ADD: begin
        n_add++;
        aim_count += amount;
      end
      OP_SUB: begin
        n_sub++;
        aim_count -= amount;
      end
      OP_REG: n_reg++;
      default: n_nop++;
    endcase
    sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one random command or short sequence
  task automatic random_command();
    int                 pick;
    logic [COUNT_W-1:0] far;
    logic [COUNT_W-1:0] jump;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // unused selector with random content
      send_command(OP_NOP, $urandom, FIBER_W'($urandom), $urandom);
    end else if (pick < 10) begin
      // far waiter, jump onto it, usually jump back
      far  = $urandom;
      jump = far - aim_count;
      send_command(OP_REG, $urandom, FIBER_W'($urandom), far);
      send_command(OP_ADD, jump, FIBER_W'($urandom), $urandom);
      if ($urandom_range(9) != 0)
        send_command(OP_SUB, jump, FIBER_W'($urandom), $urandom);
    end else if (pick < 45) begin
      // waiter near the counter so that small steps hit it
      send_command(OP_REG, $urandom, FIBER_W'($urandom),
                   aim_count + COUNT_W'($urandom_range(16)) - COUNT_W'(8));
    end else begin
      send_command($urandom_range(1) ? OP_ADD : OP_SUB, $urandom_range(6),
                   FIBER_W'($urandom), $urandom);
    end
  endtask

  initial begin
    int  phase_start;
    bit  hold_asked;
    hold_asked = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: zero add, satisfied and stored waiters, wrap both ways
    send_command(OP_ADD, '0, '1, '1);
    send_command(OP_REG, '1, 16'hFFFF, '0);
    send_command(OP_REG, '0, 16'h0000, 32'hFFFF_FFFF);
    send_command(OP_SUB, 32'd1, '0, '0);
    send_command(OP_ADD, 32'd1, '1, '1);
    send_command(OP_ADD, 32'hFFFF_FFFF, '0, '0);
    send_command(OP_NOP, '1, '1, '1);
    send_command(OP_SUB, 32'hFFFF_FFFF, '1, '1);
    // fill every slot with one target, overflow it, then release all at once
    for (int s = 0; s < WAIT_SLOTS; s++)
      send_command(OP_REG, '0, FIBER_W'(16'h100 + s), 32'd5);
    send_command(OP_REG, '0, 16'hABCD, 32'd5);
    send_command(OP_REG, '0, 16'h5432, 32'd0);
    send_command(OP_ADD, 32'd5, '0, '0);
    drain();

    // random phases under different idle patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 46;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 46;
        end
        default: begin
          idle_pct = 8;
          stall_pct <= 8;
        end
      endcase
      phase_start = sent;
      while (sent < phase_start + PHASE_ITEMS) begin
        // long output hold while commands keep coming
        if (phase == 0 && !hold_asked && sent >= phase_start + 15) begin
          hold_asked = 1'b1;
          hold_req <= 1'b1;
        end
        random_command();
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("ran %0d commands: %0d add, %0d subtract, %0d register, %0d ignored",
             sent, n_add, n_sub, n_reg, n_nop);
    $display("checked %0d result beats with %0d releases and %0d full answers",
             beats_checked, releases_seen, fulls_seen);
    if (fail_count == 0)
      $display("waitable_counter_wait_slots verification clean");
    else
      $display("waitable_counter_wait_slots verification failed");
    $finish;
  end

endmodule
